// ----- src/cfts_pkg.sv -----
package cfts_pkg;

   localparam int IDX_W      = 12;
   localparam int TIME_W     = 64;
   localparam int CNT_W      = 13;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 80;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      RD_ZERO = 3'd0,
      RD_LAST = 3'd1,
      RD_HINT = 3'd2,
      RD_J    = 3'd3,
      RD_MID  = 3'd4
   } rd_sel_type;

   typedef enum logic [1:0] {
      ANS_ZERO = 2'd0,
      ANS_LAST = 2'd1,
      ANS_PREV = 2'd2,
      ANS_LO   = 2'd3
   } ans_sel_type;

   typedef struct packed {
      logic        start;
      logic        wr;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        set_first;
      logic        scan_init;
      logic        scan_step;
      logic        bin_init;
      logic        bin_step;
      logic        ans_en;
      ans_sel_type ans_sel;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic t_lt_rd;
      logic hint_ok;
      logic j_ok;
      logic span_gt1;
      logic out_free;
   } status_type;

endpackage

// ----- src/cfts_datapath.sv -----
module cfts_datapath import cfts_pkg::*; #(
   parameter int MAX_FRAMES  = 4096,
   parameter int HINT_WINDOW = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CNT_W-1:0]   csr_wdata,
   input  logic [IDX_W-1:0]   entry_index,
   input  logic [TIME_W-1:0]  time_value,
   input  logic [IDX_W-1:0]   hint_index,
   input  cmd_type            cmd,
   output status_type         status,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [IDX_W-1:0]   frame_index,
   output logic [TIME_W-1:0]  frame_time
);

   localparam int AW = (MAX_FRAMES > 2) ? $clog2(MAX_FRAMES) : 1;
   localparam int CW = $clog2(MAX_FRAMES + 1);
   localparam int XW = (CW > IDX_W) ? CW : IDX_W;
   localparam int JW = XW + 1;

   logic [TIME_W-1:0] mem [MAX_FRAMES];

   logic [CNT_W-1:0]  frame_count_ff;
   logic [TIME_W-1:0] t_ff;
   logic [XW-1:0]     hint_ff;
   logic [CW-1:0]     n_ff, n_in;
   logic [TIME_W-1:0] rd_data_ff;
   logic [TIME_W-1:0] first_ff;
   logic [TIME_W-1:0] prev_ff;
   logic [TIME_W-1:0] lo_data_ff;
   logic [JW-1:0]     j_ff;
   logic [AW-1:0]     lo_ff, hi_ff, mid;
   logic [AW-1:0]     last_idx;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     ans_idx_ff;
   logic [TIME_W-1:0] ans_data_ff;
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic [TIME_W-1:0] rsp_time_ff;
   logic [31:0]       count_wide;
   logic              wr_ok;

   // clamp the count to 1..MAX_FRAMES
   always_comb begin
      count_wide = 32'(frame_count_ff);
      if (count_wide == 32'd0) begin
         n_in = CW'(1);
      end else if (count_wide > 32'(MAX_FRAMES)) begin
         n_in = CW'(MAX_FRAMES);
      end else begin
         n_in = CW'(count_wide);
      end
   end

   assign wr_ok    = 32'(entry_index) < 32'(MAX_FRAMES);
   assign last_idx = AW'(n_ff - CW'(1));
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_comb begin
      case (cmd.rd_sel)
         RD_ZERO: rd_addr = '0;
         RD_LAST: rd_addr = last_idx;
         RD_HINT: rd_addr = AW'(hint_ff);
         RD_J:    rd_addr = AW'(j_ff);
         RD_MID:  rd_addr = mid;
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr && wr_ok) begin
         mem[AW'(entry_index)] <= time_value;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= CNT_W'(1);
      end else if (csr_we) begin
         frame_count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         t_ff    <= time_value;
         hint_ff <= XW'(hint_index);
         n_ff    <= n_in;
      end
      if (cmd.set_first) begin
         first_ff <= rd_data_ff;
      end
      if (cmd.scan_init) begin
         j_ff    <= JW'(hint_ff) + JW'(1);
         prev_ff <= rd_data_ff;
      end else if (cmd.scan_step) begin
         j_ff    <= j_ff + JW'(1);
         prev_ff <= rd_data_ff;
      end
      if (cmd.bin_init) begin
         lo_ff      <= '0;
         hi_ff      <= last_idx;
         lo_data_ff <= first_ff;
      end else if (cmd.bin_step) begin
         if (status.t_lt_rd) begin
            hi_ff <= mid;
         end else begin
            lo_ff      <= mid;
            lo_data_ff <= rd_data_ff;
         end
      end
      if (cmd.ans_en) begin
         case (cmd.ans_sel)
            ANS_ZERO: begin
               ans_idx_ff  <= '0;
               ans_data_ff <= rd_data_ff;
            end
            ANS_LAST: begin
               ans_idx_ff  <= last_idx;
               ans_data_ff <= rd_data_ff;
            end
            ANS_PREV: begin
               ans_idx_ff  <= AW'(j_ff - JW'(1));
               ans_data_ff <= prev_ff;
            end
            ANS_LO: begin
               ans_idx_ff  <= lo_ff;
               ans_data_ff <= lo_data_ff;
            end
            default: begin
               ans_idx_ff  <= '0;
               ans_data_ff <= rd_data_ff;
            end
         endcase
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_idx_ff  <= IDX_W'(ans_idx_ff);
         rsp_time_ff <= ans_data_ff;
      end
   end

   assign status.t_lt_rd  = t_ff < rd_data_ff;
   assign status.hint_ok  = hint_ff < XW'(n_ff);
   assign status.j_ok     = (j_ff < JW'(n_ff)) &&
                            (j_ff <= JW'(hint_ff) + JW'(HINT_WINDOW));
   assign status.span_gt1 = AW'(hi_ff - lo_ff) > AW'(1);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid  = rsp_valid_ff;
   assign frame_index = rsp_idx_ff;
   assign frame_time  = rsp_time_ff;

`ifndef SYNTHESIS
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a waiting word");
   a_mid_span: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en && cmd.rd_sel == RD_MID) |-> (lo_ff < hi_ff))
      else $error("binary search read with empty span");
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en && cmd.rd_sel == RD_J) |-> (j_ff < JW'(n_ff)))
      else $error("hint scan read past frame count");
`endif

endmodule

// ----- src/cfts_ctrl.sv -----
module cfts_ctrl import cfts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_op,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b00_0000_0001,
      ST_FIRST    = 10'b00_0000_0010,
      ST_LAST     = 10'b00_0000_0100,
      ST_SCAN0    = 10'b00_0000_1000,
      ST_SCAN_RD  = 10'b00_0001_0000,
      ST_SCAN_CHK = 10'b00_0010_0000,
      ST_BIN_INIT = 10'b00_0100_0000,
      ST_BIN_RD   = 10'b00_1000_0000,
      ST_BIN_CHK  = 10'b01_0000_0000,
      ST_DONE     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_QUERY) begin
                  cmd.start  = 1'b1;
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_ZERO;
                  state_in   = ST_FIRST;
               end else begin
                  cmd.wr = 1'b1;
               end
            end
         end
         ST_FIRST: begin
            cmd.set_first = 1'b1;
            if (status.t_lt_rd) begin
               cmd.ans_en  = 1'b1;
               cmd.ans_sel = ANS_ZERO;
               state_in    = ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LAST;
               state_in   = ST_LAST;
            end
         end
         ST_LAST: begin
            if (!status.t_lt_rd) begin
               cmd.ans_en  = 1'b1;
               cmd.ans_sel = ANS_LAST;
               state_in    = ST_DONE;
            end else if (status.hint_ok) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_HINT;
               state_in   = ST_SCAN0;
            end else begin
               state_in = ST_BIN_INIT;
            end
         end
         ST_SCAN0: begin
            if (status.t_lt_rd) begin
               state_in = ST_BIN_INIT;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (status.j_ok) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_J;
               state_in   = ST_SCAN_CHK;
            end else begin
               state_in = ST_BIN_INIT;
            end
         end
         ST_SCAN_CHK: begin
            if (status.t_lt_rd) begin
               cmd.ans_en  = 1'b1;
               cmd.ans_sel = ANS_PREV;
               state_in    = ST_DONE;
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_BIN_INIT: begin
            cmd.bin_init = 1'b1;
            state_in     = ST_BIN_RD;
         end
         ST_BIN_RD: begin
            if (status.span_gt1) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_MID;
               state_in   = ST_BIN_CHK;
            end else begin
               cmd.ans_en  = 1'b1;
               cmd.ans_sel = ANS_LO;
               state_in    = ST_DONE;
            end
         end
         ST_BIN_CHK: begin
            cmd.bin_step = 1'b1;
            state_in     = ST_BIN_RD;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_query_start: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_QUERY) |=> (state_ff == ST_FIRST))
      else $error("query accepted without starting search");
   a_load_stay: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_LOAD) |=> (state_ff == ST_IDLE))
      else $error("load left the idle state");
   a_done_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && status.out_free) |=> (state_ff == ST_IDLE))
      else $error("finished search did not return to idle");
`endif

endmodule

// ----- src/closest_frame_time_search.sv -----
// Floor search over a table of up to MAX_FRAMES 64-bit frame timestamps held in
// an on-chip memory with one registered read port. A load word (tuser = 0)
// writes one entry; slots at or beyond MAX_FRAMES are dropped.
// A query word (tuser = 1) returns the largest index whose stamp is at or below
// the sought time, and that stamp; times before the first frame give frame 0,
// times at or past the last frame give the last frame. One query is in work
// at a time: the first and last entries are checked, then entries are scanned
// from the hint (up to HINT_WINDOW + 1 entries), then, if the scan misses,
// binary search steps run, and the result is handed over once the output
// register is free; each step waits on the registered memory read. The frame
// count register is written through csr_we / csr_wdata; the user must write it
// only while idle, which the block itself does not enforce; entries must be
// loaded before a query reads them, and the table needs no clearing after reset.
module closest_frame_time_search import cfts_pkg::*; #(
   parameter int MAX_FRAMES  = 4096,
   parameter int HINT_WINDOW = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CNT_W-1:0]      csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entry_index, time_value, hint_index
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // frame_index, frame_time, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   cmd_type           cmd;
   status_type        status;
   logic [IDX_W-1:0]  frame_index;
   logic [TIME_W-1:0] frame_time;

   cfts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cfts_datapath #(
      .MAX_FRAMES  (MAX_FRAMES),
      .HINT_WINDOW (HINT_WINDOW)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .entry_index (req_tdata[IDX_W-1:0]),
      .time_value  (req_tdata[IDX_W+TIME_W-1:IDX_W]),
      .hint_index  (req_tdata[2*IDX_W+TIME_W-1:IDX_W+TIME_W]),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .frame_index (frame_index),
      .frame_time  (frame_time)
   );

   assign rsp_tdata = {{(RSP_DATA_W-IDX_W-TIME_W){1'b0}}, frame_time, frame_index};

endmodule
